>>> hdl/cagb_pkg.sv
// ---------------------------------------------------------------------------
// cagb_pkg
// Shared types, constants and helpers of the clipped alpha glyph blitter.
// ---------------------------------------------------------------------------
package cagb_pkg;

  localparam int unsigned MAX_CANVAS    = 4096;
  localparam int unsigned BYTES_PER_PEL = 3;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COORD_W = 13;
  localparam int unsigned BEAR_W  = 9;
  localparam int unsigned BOX_W   = 14;
  localparam int unsigned GLYPH_W = 8;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned REG_W   = 13;
  localparam int unsigned REGIX_W = 3;
  localparam int unsigned ADDR_W  = 26;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned PROD_W  = PITCH_W + COORD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_PLOT   = 2'd2
  } cmd_t;

  typedef enum logic [REGIX_W-1:0] {
    REG_COLOR_RED   = 3'd0,
    REG_COLOR_GREEN = 3'd1,
    REG_COLOR_BLUE  = 3'd2,
    REG_CLIP_LEFT   = 3'd3,
    REG_CLIP_TOP    = 3'd4,
    REG_CLIP_RIGHT  = 3'd5,
    REG_CLIP_BOTTOM = 3'd6,
    REG_CANVAS_W    = 3'd7
  } reg_ix_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  color_red;
    logic [CHAN_W-1:0]  color_green;
    logic [CHAN_W-1:0]  color_blue;
    logic [REG_W-1:0]   clip_left;
    logic [REG_W-1:0]   clip_top;
    logic [REG_W-1:0]   clip_right;
    logic [REG_W-1:0]   clip_bottom;
    logic [REG_W-1:0]   canvas_width;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  opacity;
  } pel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic in_clip(input logic signed [BOX_W-1:0] x,
                                   input logic signed [BOX_W-1:0] y,
                                   input cfg_t cfg);
    logic signed [BOX_W:0] xs;
    logic signed [BOX_W:0] ys;
    xs = {x[BOX_W-1], x};
    ys = {y[BOX_W-1], y};
    return (xs >= $signed({2'b00, cfg.clip_left}))  &&
           (xs <  $signed({2'b00, cfg.clip_right})) &&
           (ys >= $signed({2'b00, cfg.clip_top}))   &&
           (ys <  $signed({2'b00, cfg.clip_bottom}));
  endfunction

  // floor(p / 255) for p below 65280
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W-1:0] s;
    s = p + {{(2*CHAN_W-1){1'b0}}, 1'b1} + {{CHAN_W{1'b0}}, p[2*CHAN_W-1:CHAN_W]};
    return s[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

>>> hdl/clipped_alpha_glyph_blitter_top.sv
// ---------------------------------------------------------------------------
// clipped_alpha_glyph_blitter_top
// Clipped alpha-coverage glyph blitter for a 3-byte RGB frame buffer.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    cmd, origin, bearing, glyph size, opacity
//   output   out_valid / out_ready  byte_address, out_red/green/blue
//   config   cfg_we                 cfg_index, cfg_data
//
// One transaction per cycle in and out while the queue has room and the
// output is not stalled. A write goes into the queue, then through the
// multiply stage and the output register. A stalled output holds the
// pipeline; the four-entry queue absorbs input until it fills.
// ---------------------------------------------------------------------------
module clipped_alpha_glyph_blitter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cagb_pkg::REGIX_W-1:0]       cfg_index,
  input  logic [cagb_pkg::REG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cagb_pkg::CMD_W-1:0]         cmd,
  input  logic signed [cagb_pkg::COORD_W-1:0] origin_x,
  input  logic signed [cagb_pkg::COORD_W-1:0] origin_y,
  input  logic signed [cagb_pkg::BEAR_W-1:0] bearing_x,
  input  logic signed [cagb_pkg::BEAR_W-1:0] bearing_y,
  input  logic [cagb_pkg::GLYPH_W-1:0]       glyph_cols,
  input  logic [cagb_pkg::GLYPH_W-1:0]       glyph_rows,
  input  logic [cagb_pkg::CHAN_W-1:0]        opacity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cagb_pkg::ADDR_W-1:0]        byte_address,
  output logic [cagb_pkg::CHAN_W-1:0]        out_red,
  output logic [cagb_pkg::CHAN_W-1:0]        out_green,
  output logic [cagb_pkg::CHAN_W-1:0]        out_blue
);
  import cagb_pkg::*;

  cfg_t   cfg;
  qstat_t qstat;
  logic   push;
  logic   pop;
  pel_t   push_pel;
  pel_t   head_pel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_red    <= '0;
      cfg.color_green  <= '0;
      cfg.color_blue   <= '0;
      cfg.clip_left    <= '0;
      cfg.clip_top     <= '0;
      cfg.clip_right   <= REG_W'(256);
      cfg.clip_bottom  <= REG_W'(256);
      cfg.canvas_width <= REG_W'(256);
    end else if (cfg_we) begin
      unique case (reg_ix_t'(cfg_index))
        REG_COLOR_RED:   cfg.color_red    <= cfg_data[CHAN_W-1:0];
        REG_COLOR_GREEN: cfg.color_green  <= cfg_data[CHAN_W-1:0];
        REG_COLOR_BLUE:  cfg.color_blue   <= cfg_data[CHAN_W-1:0];
        REG_CLIP_LEFT:   cfg.clip_left    <= cfg_data;
        REG_CLIP_TOP:    cfg.clip_top     <= cfg_data;
        REG_CLIP_RIGHT:  cfg.clip_right   <= cfg_data;
        REG_CLIP_BOTTOM: cfg.clip_bottom  <= cfg_data;
        REG_CANVAS_W:    cfg.canvas_width <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cagb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .bearing_x  (bearing_x),
    .bearing_y  (bearing_y),
    .glyph_cols (glyph_cols),
    .glyph_rows (glyph_rows),
    .opacity    (opacity),
    .qstat      (qstat),
    .push       (push),
    .push_pel   (push_pel)
  );

  cagb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pel (push_pel),
    .pop      (pop),
    .head_pel (head_pel),
    .qstat    (qstat)
  );

  cagb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_pel     (head_pel),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_address (byte_address),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

endmodule

>>> hdl/cagb_front.sv
// ---------------------------------------------------------------------------
// cagb_front
// Accepts commands, tracks the open glyph box and classifies each pixel
// against the clip rectangle; pixels inside go to the queue.
// ---------------------------------------------------------------------------
module cagb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  cagb_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cagb_pkg::CMD_W-1:0]         cmd,
  input  logic signed [cagb_pkg::COORD_W-1:0] origin_x,
  input  logic signed [cagb_pkg::COORD_W-1:0] origin_y,
  input  logic signed [cagb_pkg::BEAR_W-1:0] bearing_x,
  input  logic signed [cagb_pkg::BEAR_W-1:0] bearing_y,
  input  logic [cagb_pkg::GLYPH_W-1:0]       glyph_cols,
  input  logic [cagb_pkg::GLYPH_W-1:0]       glyph_rows,
  input  logic [cagb_pkg::CHAN_W-1:0]        opacity,
  input  cagb_pkg::qstat_t                   qstat,
  output logic                               push,
  output cagb_pkg::pel_t                     push_pel
);
  import cagb_pkg::*;

  logic signed [BOX_W-1:0] box_left;
  logic signed [BOX_W-1:0] box_top;
  logic [GLYPH_W-1:0]      box_cols;
  logic [GLYPH_W-1:0]      box_rows;
  logic [GLYPH_W-1:0]      column_count;
  logic [GLYPH_W-1:0]      row_count;
  logic                    glyph_open;

  logic                    accept;
  logic                    sample_live;
  logic signed [BOX_W-1:0] pt_x;
  logic signed [BOX_W-1:0] pt_y;
  logic                    emit;
  logic [GLYPH_W-1:0]      col_inc;
  logic [GLYPH_W-1:0]      row_inc;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign sample_live = glyph_open && (box_cols != '0) && (row_count < box_rows);
  assign col_inc  = column_count + GLYPH_W'(1);
  assign row_inc  = row_count + GLYPH_W'(1);

  always_comb begin
    pt_x = {origin_x[COORD_W-1], origin_x};
    pt_y = {origin_y[COORD_W-1], origin_y};
    emit = 1'b0;
    unique case (cmd)
      CMD_SAMPLE: begin
        pt_x = box_left + $signed({{(BOX_W-GLYPH_W){1'b0}}, column_count});
        pt_y = box_top + $signed({{(BOX_W-GLYPH_W){1'b0}}, row_count});
        emit = sample_live && in_clip(pt_x, pt_y, cfg);
      end
      CMD_PLOT: begin
        emit = in_clip(pt_x, pt_y, cfg);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push         = accept && emit;
  assign push_pel.x   = pt_x[COORD_W-1:0];
  assign push_pel.y   = pt_y[COORD_W-1:0];
  assign push_pel.opacity = (cmd == CMD_PLOT) ? {CHAN_W{1'b1}} : opacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left     <= '0;
      box_top      <= '0;
      box_cols     <= '0;
      box_rows     <= '0;
      column_count <= '0;
      row_count    <= '0;
      glyph_open   <= 1'b0;
    end else if (accept) begin
      unique case (cmd)
        CMD_BEGIN: begin
          box_left     <= BOX_W'(origin_x) + BOX_W'(bearing_x);
          box_top      <= BOX_W'(origin_y) - BOX_W'(bearing_y);
          box_cols     <= glyph_cols;
          box_rows     <= glyph_rows;
          column_count <= '0;
          row_count    <= '0;
          glyph_open   <= 1'b1;
        end
        CMD_SAMPLE: begin
          if (!sample_live) begin
            glyph_open <= 1'b0;
          end else if (col_inc >= box_cols) begin
            column_count <= '0;
            row_count    <= row_inc;
            if (row_inc >= box_rows) begin
              glyph_open <= 1'b0;
            end
          end else begin
            column_count <= col_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/cagb_queue.sv
// ---------------------------------------------------------------------------
// cagb_queue
// Short pixel queue between the front classifier and the back pipeline.
// ---------------------------------------------------------------------------
module cagb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cagb_pkg::pel_t   push_pel,
  input  logic             pop,
  output cagb_pkg::pel_t   head_pel,
  output cagb_pkg::qstat_t qstat
);
  import cagb_pkg::*;

  pel_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_pel    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_pel;
    end
  end

endmodule

>>> hdl/cagb_back.sv
// ---------------------------------------------------------------------------
// cagb_back
// Two-stage write pipeline: multiply address and channels, then divide by
// 255, add the column offset and hold the result in the output register.
// ---------------------------------------------------------------------------
module cagb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  cagb_pkg::cfg_t                 cfg,
  input  cagb_pkg::pel_t                 head_pel,
  input  cagb_pkg::qstat_t               qstat,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cagb_pkg::ADDR_W-1:0]    byte_address,
  output logic [cagb_pkg::CHAN_W-1:0]    out_red,
  output logic [cagb_pkg::CHAN_W-1:0]    out_green,
  output logic [cagb_pkg::CHAN_W-1:0]    out_blue
);
  import cagb_pkg::*;

  logic                  advance;
  logic [REG_W-1:0]      width_sat;
  logic [PITCH_W-1:0]    pitch;

  logic                  s1_valid;
  logic [PROD_W-1:0]     row_off;
  logic [PITCH_W-1:0]    col_off;
  logic [2*CHAN_W-1:0]   prod_red;
  logic [2*CHAN_W-1:0]   prod_green;
  logic [2*CHAN_W-1:0]   prod_blue;
  logic [PROD_W-1:0]     addr_sum;

  always_comb begin
    width_sat = cfg.canvas_width;
    if (cfg.canvas_width == '0) begin
      width_sat = REG_W'(1);
    end else if (cfg.canvas_width > REG_W'(MAX_CANVAS)) begin
      width_sat = REG_W'(MAX_CANVAS);
    end
  end

  assign pitch    = PITCH_W'(BYTES_PER_PEL) * PITCH_W'(width_sat);
  assign advance  = !out_valid || out_ready;
  assign pop      = advance && !qstat.empty;
  assign addr_sum = row_off + PROD_W'(col_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !qstat.empty;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row_off      <= PROD_W'(pitch) * PROD_W'(head_pel.y);
      col_off      <= PITCH_W'(BYTES_PER_PEL) * PITCH_W'(head_pel.x);
      prod_red     <= {{CHAN_W{1'b0}}, head_pel.opacity} * {{CHAN_W{1'b0}}, cfg.color_red};
      prod_green   <= {{CHAN_W{1'b0}}, head_pel.opacity} * {{CHAN_W{1'b0}}, cfg.color_green};
      prod_blue    <= {{CHAN_W{1'b0}}, head_pel.opacity} * {{CHAN_W{1'b0}}, cfg.color_blue};
      byte_address <= addr_sum[ADDR_W-1:0];
      out_red      <= div255(prod_red);
      out_green    <= div255(prod_green);
      out_blue     <= div255(prod_blue);
    end
  end

endmodule

>>> hdl/cagb_checker.sv
// ---------------------------------------------------------------------------
// cagb_checker
// Port-level checks of the glyph blitter, bound to the top level.
// ---------------------------------------------------------------------------
module cagb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cagb_pkg::ADDR_W-1:0]     byte_address,
  input logic [cagb_pkg::CHAN_W-1:0]     out_red,
  input logic [cagb_pkg::CHAN_W-1:0]     out_green,
  input logic [cagb_pkg::CHAN_W-1:0]     out_blue
);
  import cagb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(byte_address) && $stable(out_red) &&
                                $stable(out_green) && $stable(out_blue))
    else $error("stalled output payload changed");

  a_reset_latency: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid)
    else $error("output transaction too soon after reset");

  a_full_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked while output side is idle");

endmodule

bind clipped_alpha_glyph_blitter_top cagb_checker u_cagb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .byte_address (byte_address),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue)
);

>>> test/tb_clipped_alpha_glyph_blitter_top.sv
// ---------------------------------------------------------------------------
// tb_clipped_alpha_glyph_blitter_top
// Self-checking bench for the clipped alpha glyph blitter. A directed table
// covers reset values, clip and canvas extremes and glyph open/close
// behavior. Random phases follow with sender and receiver throttling, glyph
// sequences of exact, short and long sample runs, plots and noise. Each
// frame-buffer write is checked per field against a behavioral predictor.
// ---------------------------------------------------------------------------
module tb_clipped_alpha_glyph_blitter_top;
  import cagb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } fb_write_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [BEAR_W-1:0]  bx;
    logic signed [BEAR_W-1:0]  by;
    logic [GLYPH_W-1:0]        cols;
    logic [GLYPH_W-1:0]        rows;
    logic [CHAN_W-1:0]         op;
    bit                        typed;
    bit                        t_hit;
    fb_write_t                 t_wr;
  } blit_item_t;

  typedef struct {
    bit         is_reg;
    reg_ix_t    ix;
    int         val;
    blit_item_t it;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [REGIX_W-1:0]         cfg_index = '0;
  logic [REG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           cmd = '0;
  logic signed [COORD_W-1:0]  origin_x = '0;
  logic signed [COORD_W-1:0]  origin_y = '0;
  logic signed [BEAR_W-1:0]   bearing_x = '0;
  logic signed [BEAR_W-1:0]   bearing_y = '0;
  logic [GLYPH_W-1:0]         glyph_cols = '0;
  logic [GLYPH_W-1:0]         glyph_rows = '0;
  logic [CHAN_W-1:0]          opacity = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ADDR_W-1:0]          byte_address;
  logic [CHAN_W-1:0]          out_red;
  logic [CHAN_W-1:0]          out_green;
  logic [CHAN_W-1:0]          out_blue;

  clipped_alpha_glyph_blitter_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and glyph walker state
  cfg_t shadow_cfg = '{clip_right: 256, clip_bottom: 256, canvas_width: 256, default: '0};
  int   glyph_x0 = 0;
  int   glyph_y0 = 0;
  int   glyph_w = 0;
  int   glyph_h = 0;
  int   col_pos = 0;
  int   row_pos = 0;
  bit   glyph_live = 1'b0;

  blit_item_t send_q[$];
  fb_write_t  write_q[$];
  blit_item_t on_port;
  int         queued = 0;
  int         fail_count = 0;
  int         send_idle = 36;
  int         recv_idle = 67;
  int         hold_left = 0;

  function automatic bit pel_visible(int x, int y);
    return x >= int'(shadow_cfg.clip_left) && x < int'(shadow_cfg.clip_right) &&
           y >= int'(shadow_cfg.clip_top) && y < int'(shadow_cfg.clip_bottom);
  endfunction

  function automatic logic [ADDR_W-1:0] pel_addr(int x, int y);
    longint w;
    w = longint'(shadow_cfg.canvas_width);
    if (w < 1) w = 1;
    if (w > MAX_CANVAS) w = MAX_CANVAS;
    return ADDR_W'(BYTES_PER_PEL * w * y + BYTES_PER_PEL * x);
  endfunction

  function automatic logic [CHAN_W-1:0] scale(logic [CHAN_W-1:0] op, logic [CHAN_W-1:0] c);
    return CHAN_W'((int'(op) * int'(c)) / 255);
  endfunction

  function automatic bit blit_step(input blit_item_t it, output fb_write_t wr);
    int x;
    int y;
    wr = '{default: '0};
    case (it.cmd)
      CMD_BEGIN: begin
        glyph_x0 = int'(it.ox) + int'(it.bx);
        glyph_y0 = int'(it.oy) - int'(it.by);
        glyph_w = int'(it.cols);
        glyph_h = int'(it.rows);
        col_pos = 0;
        row_pos = 0;
        glyph_live = 1'b1;
        return 1'b0;
      end
      CMD_SAMPLE: begin
        if (!glyph_live || glyph_w == 0 || row_pos >= glyph_h) begin
          glyph_live = 1'b0;
          return 1'b0;
        end
        x = glyph_x0 + col_pos;
        y = glyph_y0 + row_pos;
        col_pos++;
        if (col_pos >= glyph_w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= glyph_h) glyph_live = 1'b0;
        end
        if (!pel_visible(x, y)) return 1'b0;
        wr.addr = pel_addr(x, y);
        wr.red = scale(it.op, shadow_cfg.color_red);
        wr.green = scale(it.op, shadow_cfg.color_green);
        wr.blue = scale(it.op, shadow_cfg.color_blue);
        return 1'b1;
      end
      CMD_PLOT: begin
        if (!pel_visible(int'(it.ox), int'(it.oy))) return 1'b0;
        wr.addr = pel_addr(int'(it.ox), int'(it.oy));
        wr.red = shadow_cfg.color_red;
        wr.green = shadow_cfg.color_green;
        wr.blue = shadow_cfg.color_blue;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // input side: predict on each transaction, then offer the next item
  always @(posedge clk) begin : drive_in
    fb_write_t wr;
    bit        hit;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hit = blit_step(on_port, wr);
        if (on_port.typed) begin
          hit = on_port.t_hit;
          wr = on_port.t_wr;
        end
        if (hit) write_q.push_back(wr);
      end
      if (!in_valid || in_ready) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          on_port = send_q.pop_front();
          in_valid <= 1'b1;
          cmd <= on_port.cmd;
          origin_x <= on_port.ox;
          origin_y <= on_port.oy;
          bearing_x <= on_port.bx;
          bearing_y <= on_port.by;
          glyph_cols <= on_port.cols;
          glyph_rows <= on_port.rows;
          opacity <= on_port.op;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_out
    fb_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (write_q.size() == 0) begin
        $display("%0t unexpected write: expected none, actual addr %0d rgb %0d %0d %0d",
                 $time, byte_address, out_red, out_green, out_blue);
        fail_count++;
      end else begin
        want = write_q.pop_front();
        check_field("byte_address", 32'(want.addr), 32'(byte_address));
        check_field("out_red", 32'(want.red), 32'(out_red));
        check_field("out_green", 32'(want.green), 32'(out_green));
        check_field("out_blue", 32'(want.blue), 32'(out_blue));
      end
    end
  end

  task automatic drain();
    do @(negedge clk); while (send_q.size() != 0 || in_valid || write_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(reg_ix_t ix, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= REG_W'(val);
    case (ix)
      REG_COLOR_RED:   shadow_cfg.color_red = CHAN_W'(val);
      REG_COLOR_GREEN: shadow_cfg.color_green = CHAN_W'(val);
      REG_COLOR_BLUE:  shadow_cfg.color_blue = CHAN_W'(val);
      REG_CLIP_LEFT:   shadow_cfg.clip_left = REG_W'(val);
      REG_CLIP_TOP:    shadow_cfg.clip_top = REG_W'(val);
      REG_CLIP_RIGHT:  shadow_cfg.clip_right = REG_W'(val);
      REG_CLIP_BOTTOM: shadow_cfg.clip_bottom = REG_W'(val);
      default:         shadow_cfg.canvas_width = REG_W'(val);
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void offer(blit_item_t it);
    send_q.push_back(it);
    queued++;
  endfunction

  function automatic blit_item_t rand_item(logic [CMD_W-1:0] c);
    blit_item_t it;
    it = '{default: '0};
    it.cmd = c;
    it.ox = COORD_W'($urandom);
    it.oy = COORD_W'($urandom);
    it.bx = BEAR_W'($urandom);
    it.by = BEAR_W'($urandom);
    it.cols = GLYPH_W'($urandom);
    it.rows = GLYPH_W'($urandom);
    it.op = CHAN_W'($urandom);
    return it;
  endfunction

  function automatic int near_span(int lo, int hi);
    if (hi <= lo) return lo - 2 + int'($urandom_range(0, 4));
    return lo - 3 + int'($urandom_range(0, hi - lo + 5));
  endfunction

  function automatic int clamp_coord(int v);
    return v < -4096 ? -4096 : (v > 4095 ? 4095 : v);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_opacity();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic void queue_plot();
    blit_item_t it;
    it = rand_item(CMD_PLOT);
    if ($urandom_range(0, 9) < 7) begin
      it.ox = COORD_W'(clamp_coord(near_span(int'(shadow_cfg.clip_left),
                                             int'(shadow_cfg.clip_right))));
      it.oy = COORD_W'(clamp_coord(near_span(int'(shadow_cfg.clip_top),
                                             int'(shadow_cfg.clip_bottom))));
    end
    offer(it);
  endfunction

  function automatic void queue_glyph();
    blit_item_t it;
    int cols;
    int rows;
    int n;
    int bx;
    int by;
    case ($urandom_range(0, 19))
      0: begin
        cols = $urandom_range(128, 255);
        rows = 1;
      end
      1: begin
        cols = 1;
        rows = $urandom_range(128, 255);
      end
      2: begin
        cols = 0;
        rows = $urandom_range(0, 255);
      end
      default: begin
        cols = $urandom_range(1, 6);
        rows = $urandom_range(1, 4);
      end
    endcase
    bx = int'($urandom_range(0, 511)) - 256;
    by = int'($urandom_range(0, 511)) - 256;
    it = rand_item(CMD_BEGIN);
    it.bx = BEAR_W'(bx);
    it.by = BEAR_W'(by);
    it.ox = COORD_W'(clamp_coord(near_span(int'(shadow_cfg.clip_left),
                                           int'(shadow_cfg.clip_right)) - bx));
    it.oy = COORD_W'(clamp_coord(near_span(int'(shadow_cfg.clip_top),
                                           int'(shadow_cfg.clip_bottom)) + by));
    it.cols = GLYPH_W'(cols);
    it.rows = GLYPH_W'(rows);
    offer(it);
    n = cols * rows;
    case ($urandom_range(0, 9))
      0:       if (n > 0) n = n - 1;
      1:       n = n + 2;
      default: if (n == 0) n = 1;
    endcase
    repeat (n) begin
      it = rand_item(CMD_SAMPLE);
      it.op = pick_opacity();
      offer(it);
    end
  endfunction

  task automatic set_phase_cfg(int kind);
    int l;
    int t;
    set_reg(REG_COLOR_RED, kind == 0 ? 255 : int'($urandom_range(0, 255)));
    set_reg(REG_COLOR_GREEN, kind == 0 ? 0 : int'($urandom_range(0, 255)));
    set_reg(REG_COLOR_BLUE, $urandom_range(0, 255));
    case (kind)
      0: begin
        set_reg(REG_CLIP_LEFT, 0);
        set_reg(REG_CLIP_TOP, 0);
        set_reg(REG_CLIP_RIGHT, 4096);
        set_reg(REG_CLIP_BOTTOM, 4096);
        set_reg(REG_CANVAS_W, 4096);
      end
      1: begin
        l = $urandom_range(0, 4000);
        t = $urandom_range(0, 4000);
        set_reg(REG_CLIP_LEFT, l);
        set_reg(REG_CLIP_TOP, t);
        set_reg(REG_CLIP_RIGHT, l + int'($urandom_range(1, 96)));
        set_reg(REG_CLIP_BOTTOM, t + int'($urandom_range(1, 96)));
        set_reg(REG_CANVAS_W, $urandom_range(1, 4096));
      end
      default: begin
        // empty or inverted clip
        l = $urandom_range(1, 4096);
        set_reg(REG_CLIP_LEFT, l);
        set_reg(REG_CLIP_TOP, 0);
        set_reg(REG_CLIP_RIGHT, $urandom_range(0, l));
        set_reg(REG_CLIP_BOTTOM, 4096);
        set_reg(REG_CANVAS_W, 1);
      end
    endcase
    end_writes();
  endtask

  function automatic dir_row_t item_row(logic [CMD_W-1:0] c, int ox, int oy, int bx, int by,
                                        int cols, int rows, int op);
    dir_row_t r;
    r = '{is_reg: 1'b0, ix: REG_COLOR_RED, val: 0, it: '{default: '0}};
    r.it.cmd = c;
    r.it.ox = COORD_W'(ox);
    r.it.oy = COORD_W'(oy);
    r.it.bx = BEAR_W'(bx);
    r.it.by = BEAR_W'(by);
    r.it.cols = GLYPH_W'(cols);
    r.it.rows = GLYPH_W'(rows);
    r.it.op = CHAN_W'(op);
    return r;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t r, bit hit, int addr, int red, int green,
                                         int blue);
    r.it.typed = 1'b1;
    r.it.t_hit = hit;
    r.it.t_wr.addr = ADDR_W'(addr);
    r.it.t_wr.red = CHAN_W'(red);
    r.it.t_wr.green = CHAN_W'(green);
    r.it.t_wr.blue = CHAN_W'(blue);
    return r;
  endfunction

  function automatic dir_row_t reg_row(reg_ix_t ix, int val);
    dir_row_t r;
    r = '{is_reg: 1'b0, ix: REG_COLOR_RED, val: 0, it: '{default: '0}};
    r.is_reg = 1'b1;
    r.ix = ix;
    r.val = val;
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t dir_tab[$];
    bit       in_cfg;
    int       p;
    int       target;
    int       pick;
    in_cfg = 1'b0;

    dir_tab.push_back(typed_row(item_row(CMD_PLOT, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(item_row(CMD_PLOT, 255, 255, 0, 0, 0, 0, 0),
                                1, 196605, 0, 0, 0));
    dir_tab.push_back(typed_row(item_row(CMD_PLOT, 256, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(item_row(CMD_PLOT, -4096, 4095, 0, 0, 0, 0, 0),
                                0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(item_row(CMD_UNUSED, -1, -1, -1, -1, 255, 255, 255),
                                0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 255), 0, 0, 0, 0, 0));
    dir_tab.push_back(reg_row(REG_COLOR_RED, 255));
    dir_tab.push_back(reg_row(REG_COLOR_GREEN, 128));
    dir_tab.push_back(reg_row(REG_COLOR_BLUE, 0));
    dir_tab.push_back(typed_row(item_row(CMD_PLOT, 10, 2, 0, 0, 0, 0, 0),
                                1, 1566, 255, 128, 0));
    dir_tab.push_back(item_row(CMD_BEGIN, 5, 5, 2, 3, 2, 2, 0));
    dir_tab.push_back(typed_row(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 255),
                                1, 1557, 255, 128, 0));
    dir_tab.push_back(typed_row(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 1, 1560, 0, 0, 0));
    dir_tab.push_back(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 128));
    dir_tab.push_back(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(typed_row(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 200), 0, 0, 0, 0, 0));
    dir_tab.push_back(item_row(CMD_BEGIN, 0, 0, 0, 0, 0, 5, 0));
    dir_tab.push_back(typed_row(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 90), 0, 0, 0, 0, 0));
    dir_tab.push_back(item_row(CMD_BEGIN, -4096, 4095, -256, 255, 255, 255, 0));
    dir_tab.push_back(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 77));
    dir_tab.push_back(reg_row(REG_CLIP_LEFT, 10));
    dir_tab.push_back(reg_row(REG_CLIP_RIGHT, 12));
    dir_tab.push_back(reg_row(REG_CLIP_BOTTOM, 4096));
    dir_tab.push_back(reg_row(REG_CANVAS_W, 4096));
    dir_tab.push_back(item_row(CMD_BEGIN, 8, 4095, 0, 0, 5, 1, 0));
    repeat (5) dir_tab.push_back(item_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 255));
    dir_tab.push_back(reg_row(REG_CANVAS_W, 0));
    dir_tab.push_back(reg_row(REG_CLIP_LEFT, 0));
    dir_tab.push_back(typed_row(item_row(CMD_PLOT, 3, 2, 0, 0, 0, 0, 0), 1, 15, 255, 128, 0));
    dir_tab.push_back(reg_row(REG_CANVAS_W, 8191));
    dir_tab.push_back(typed_row(item_row(CMD_PLOT, 1, 1, 0, 0, 0, 0, 0),
                                1, 12291, 255, 128, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        if (!in_cfg) begin
          drain();
          in_cfg = 1'b1;
        end
        set_reg(dir_tab[i].ix, dir_tab[i].val);
      end else begin
        if (in_cfg) begin
          end_writes();
          in_cfg = 1'b0;
        end
        offer(dir_tab[i].it);
      end
    end

    for (p = 0; p < 9; p++) begin
      drain();
      send_idle = (p / 3 == 0) ? 36 : ((p / 3 == 1) ? 67 : 0);
      recv_idle = (p / 3 == 0) ? 67 : ((p / 3 == 1) ? 36 : 0);
      set_phase_cfg(p % 3);
      if (p == 0) begin
        // hold the output long enough to fill the queue
        @(negedge clk);
        hold_left = 150;
      end
      target = queued + 30;
      while (queued < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) offer(rand_item(CMD_W'($urandom_range(0, 3))));
        else if (pick < 22) queue_plot();
        else queue_glyph();
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS clipped_alpha_glyph_blitter_top");
    end else begin
      $display("FAIL clipped_alpha_glyph_blitter_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL clipped_alpha_glyph_blitter_top");
    $finish;
  end

endmodule
